/* hw/rtl/spp_pkg.sv */
// Shared types, codes and helpers of the SP-PIFO packet scheduler.
package spp_pkg;

	localparam int RANK_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int ENTRY_W  = HANDLE_W + RANK_W;

	// operation carried by the func field
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DROP  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_UPD
	} state_t;

	// signed 32-bit a >= b on raw bit patterns
	function automatic logic sge32(input logic [RANK_W-1:0] a, input logic [RANK_W-1:0] b);
		return signed'(a) >= signed'(b);
	endfunction

endpackage

/* hw/rtl/spp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module spp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/spp_bounds.sv */
// Queue bound registers: target search by rank, push-up and push-down updates.
module spp_bounds #(
	parameter int NUM_QUEUES = 8,
	parameter int QW         = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [spp_pkg::RANK_W-1:0]    rank,
	input  logic                          upd,
	output logic [QW-1:0]                 target,
	output logic                          found
);
	import spp_pkg::*;

	logic [RANK_W-1:0] bnd_q [NUM_QUEUES];

	// highest-index queue whose bound is at most the rank wins
	always_comb begin
		found  = 1'b0;
		target = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (sge32(rank, bnd_q[i])) begin
				found  = 1'b1;
				target = QW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				bnd_q[i] <= '0;
			end
		end else if (upd) begin
			if (found) begin
				for (int i = 0; i < NUM_QUEUES; i++) begin
					if (QW'(i) == target) begin
						bnd_q[i] <= rank;
					end
				end
			end else begin
				// push down: shift every bound by bound0 - rank
				bnd_q[0] <= rank;
				for (int i = 1; i < NUM_QUEUES; i++) begin
					bnd_q[i] <= bnd_q[i] - bnd_q[0] + rank;
				end
			end
		end
	end

	a_push_down_sets_head: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && !found) |=> (bnd_q[0] == $past(rank)))
		else $error("push-down did not set bound 0 to the rank");

	a_target_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> sge32(rank, bnd_q[target]))
		else $error("chosen queue bound exceeds the rank");

	a_head_bound_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> (bnd_q[0] == $past(bnd_q[0])))
		else $error("bound 0 moved without an update");

endmodule

/* hw/rtl/sp_pifo_packet_scheduler.sv */
// Top level of the SP-PIFO packet scheduler: sequencer, FIFO bookkeeping, memories.
//
// SP-PIFO approximates a push-in-first-out queue with NUM_QUEUES strict-priority
// FIFOs. An enqueue beat (func = 0) takes the start-time fair-queueing rank of
// its flow (greater of current round and the flow's last finish round), picks
// the lowest-priority FIFO whose bound does not exceed that rank and raises the
// bound to it, or falls back to FIFO 0 and lowers every bound (push-down). A
// full target drops the packet. A dequeue beat (func = 1) serves the head of
// the highest-priority non-empty FIFO and moves the current round to its rank.
// Every input beat yields exactly one result beat. One item is in
// flight at a time; a dequeue steps through head lookup and FIFO memory read,
// then commit, and an enqueue through finish-round memory read, rank, then
// bound compare and commit, as both memories have registered read data. A
// finished result sits in the output register, so the next beat is taken
// while it waits; a result commits only once the output register is free.
// After reset the flow finish-round memory is cleared one entry per cycle,
// all NUM_FLOWS entries, with in_stall held high. The FIFO entry memory
// needs no clearing: only written entries are ever used.
module sp_pifo_packet_scheduler #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int NUM_FLOWS   = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [7:0]                          flow_id,
	input  logic [spp_pkg::WEIGHT_W-1:0]        flow_weight,
	input  logic [spp_pkg::HANDLE_W-1:0]        packet_handle,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic [2:0]                          queue_index,
	output logic [spp_pkg::HANDLE_W-1:0]        packet_handle_out,
	output logic signed [spp_pkg::RANK_W-1:0]   packet_rank
);
	import spp_pkg::*;

	localparam int QW      = $clog2(NUM_QUEUES);
	localparam int HW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int FW      = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = $clog2(ENTRIES);

	state_t state_q, state_d;

	// sequencer strobes
	logic in_acc, res_load, enq_commit, deq_commit;
	logic flow_re, flow_we, fifo_re, fifo_we;
	logic out_free;
	status_t res_status_d;

	// captured beat
	logic                func_q;
	logic [FW-1:0]       flow_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [QW-1:0]       deq_q_s1;
	logic                deq_found_s1;
	logic [RANK_W-1:0]   rank_q;

	// scheduler state outside the memories
	logic [RANK_W-1:0] current_round_q;
	logic [CW-1:0]     cnt_q  [NUM_QUEUES];
	logic [HW-1:0]     head_q [NUM_QUEUES];
	logic [FW-1:0]     clr_q;

	// output register
	logic                out_valid_q;
	status_t             status_q;
	logic [QW-1:0]       qidx_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic [RANK_W-1:0]   rank_out_q;

	// flow index reduction table
	logic [FW-1:0] flow_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_flow_lut
		assign flow_lut[g] = FW'(g % NUM_FLOWS);
	end

	// memories
	logic [FW-1:0]      flow_waddr;
	logic [RANK_W-1:0]  flow_wdata, flow_rdata;
	logic [AW-1:0]      fifo_base, fifo_raddr, fifo_waddr;
	logic [ENTRY_W-1:0] fifo_rdata;

	spp_ram #(.WIDTH(RANK_W), .DEPTH(NUM_FLOWS)) u_flow_ram (
		.clk   (clk),
		.we    (flow_we),
		.waddr (flow_waddr),
		.wdata (flow_wdata),
		.re    (flow_re),
		.raddr (flow_lut[flow_id]),
		.rdata (flow_rdata)
	);

	spp_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata ({handle_q, rank_q}),
		.re    (fifo_re),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	// bound registers and target choice
	logic [QW-1:0] tgt;
	logic          tgt_found;

	spp_bounds #(.NUM_QUEUES(NUM_QUEUES), .QW(QW)) u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.rank   (rank_q),
		.upd    (enq_commit),
		.target (tgt),
		.found  (tgt_found)
	);

	// Highest-priority non-empty FIFO: lowest index with a non-zero count.
	logic [QW-1:0] deq_sel;
	logic          deq_found;

	always_comb begin
		deq_found = 1'b0;
		deq_sel   = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				deq_found = 1'b1;
				deq_sel   = QW'(i);
			end
		end
	end

	// One read port into the head/count registers; the state picks the queue.
	logic [QW-1:0] sel_idx;
	logic [CW-1:0] sel_cnt;
	logic [HW-1:0] sel_head;

	always_comb begin
		case (state_q)
			S_IDLE:  sel_idx = deq_sel;
			S_RD:    sel_idx = deq_q_s1;
			S_UPD:   sel_idx = tgt;
			default: sel_idx = tgt;
		endcase
	end

	assign sel_cnt  = cnt_q[sel_idx];
	assign sel_head = head_q[sel_idx];

	logic          full;
	logic [CW:0]   slot_sum, slot_wrap;
	logic [HW-1:0] slot;
	logic [HW:0]   head_inc;
	logic [HW-1:0] head_nxt;

	assign full      = (sel_cnt == CW'(QUEUE_DEPTH));
	assign slot_sum  = (CW + 1)'(sel_head) + (CW + 1)'(sel_cnt);
	assign slot_wrap = (slot_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
		slot_sum - (CW + 1)'(QUEUE_DEPTH) : slot_sum;
	assign slot      = HW'(slot_wrap);
	assign head_inc  = (HW + 1)'(sel_head) + (HW + 1)'(1);
	assign head_nxt  = (head_inc == (HW + 1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);

	assign fifo_base  = AW'(sel_idx) * AW'(QUEUE_DEPTH);
	assign fifo_raddr = fifo_base + AW'(sel_head);
	assign fifo_waddr = fifo_base + AW'(slot);

	assign flow_waddr = (state_q == S_CLR) ? clr_q : flow_q;
	assign flow_wdata = (state_q == S_CLR) ? '0 : rank_q + RANK_W'(weight_q);

	assign out_free = !out_valid_q || !out_stall;

	// next state and strobes
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		in_acc       = 1'b0;
		flow_re      = 1'b0;
		flow_we      = 1'b0;
		fifo_re      = 1'b0;
		fifo_we      = 1'b0;
		res_load     = 1'b0;
		enq_commit   = 1'b0;
		deq_commit   = 1'b0;
		res_status_d = ST_EMPTY;
		case (state_q)
			S_CLR: begin
				flow_we = 1'b1;
				if (clr_q == FW'(NUM_FLOWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					in_acc  = 1'b1;
					flow_re = 1'b1;
					fifo_re = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (func_q == FUNC_ENQ) begin
					state_d = S_UPD;
				end else if (out_free) begin
					res_load     = 1'b1;
					res_status_d = deq_found_s1 ? ST_DEQ : ST_EMPTY;
					deq_commit   = deq_found_s1;
					state_d      = S_IDLE;
				end
			end
			S_UPD: begin
				if (out_free) begin
					res_load     = 1'b1;
					res_status_d = full ? ST_DROP : ST_ENQ;
					enq_commit   = !full;
					fifo_we      = !full;
					flow_we      = !full;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the beat, form the rank
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q       <= func;
			flow_q       <= flow_lut[flow_id];
			weight_q     <= flow_weight;
			handle_q     <= packet_handle;
			deq_q_s1     <= deq_sel;
			deq_found_s1 <= deq_found;
		end
		if (state_q == S_RD) begin
			rank_q <= sge32(current_round_q, flow_rdata) ? current_round_q : flow_rdata;
		end
	end

	// FIFO bookkeeping, round, clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
			current_round_q <= '0;
			clr_q           <= '0;
		end else begin
			if (state_q == S_CLR) begin
				clr_q <= clr_q + FW'(1);
			end
			if (enq_commit) begin
				cnt_q[tgt] <= sel_cnt + CW'(1);
			end
			if (deq_commit) begin
				cnt_q[deq_q_s1]  <= sel_cnt - CW'(1);
				head_q[deq_q_s1] <= head_nxt;
				current_round_q  <= fifo_rdata[RANK_W-1:0];
			end
		end
	end

	// output register: hold while stalled, reload once free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status_d;
			if (state_q == S_UPD) begin
				qidx_q       <= tgt;
				handle_out_q <= handle_q;
				rank_out_q   <= rank_q;
			end else if (deq_found_s1) begin
				qidx_q       <= deq_q_s1;
				handle_out_q <= fifo_rdata[ENTRY_W-1:RANK_W];
				rank_out_q   <= fifo_rdata[RANK_W-1:0];
			end else begin
				qidx_q       <= '0;
				handle_out_q <= '0;
				rank_out_q   <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign queue_index       = 3'(qidx_q);
	assign packet_handle_out = handle_out_q;
	assign packet_rank       = signed'(rank_out_q);

	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_cnt_chk
		a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
			cnt_q[g] <= CW'(QUEUE_DEPTH))
			else $error("FIFO count above depth");
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_RD))
		else $error("accepted beat did not move to the memory read step");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_status_d == ST_DEQ) |-> (sel_cnt != '0))
		else $error("dequeue served an empty FIFO");

	a_flow_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		flow_we |-> (state_q == S_UPD || state_q == S_CLR))
		else $error("finish-round write outside commit or clear");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the SP-PIFO packet scheduler: directed table plus random phases.
module testbench;
	import spp_pkg::*;

	localparam int NUM_Q   = 8;
	localparam int Q_DEPTH = 64;
	localparam int N_FLOWS = 256;
	localparam int ITEM_BUDGET = 600;

	// one input beat: operation code and packet descriptor fields
	typedef struct packed {
		logic        func;
		logic [7:0]  flow;
		logic [15:0] weight;
		logic [15:0] handle;
	} sched_op_t;

	// one result beat as the scheduler reports it
	typedef struct packed {
		status_t     st;
		logic [2:0]  qidx;
		logic [15:0] handle;
		logic [31:0] rank;
	} sched_result_t;

	// FIFO slot held by the shadow scheduler
	typedef struct packed {
		logic [15:0] handle;
		logic [31:0] rank;
	} fifo_slot_t;

	// directed row: beat, how many times to send it (handle advances each time),
	// and the result written out by hand where it is obvious
	typedef struct packed {
		sched_op_t     op;
		logic [7:0]    reps;
		logic          typed;
		sched_result_t want;
	} stim_row_t;

	localparam sched_result_t UNTYPED = '{ST_ENQ, 3'd0, 16'd0, 32'd0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  flow_id;
	logic [15:0] flow_weight;
	logic [15:0] packet_handle;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [2:0]  queue_index;
	logic [15:0] packet_handle_out;
	logic signed [31:0] packet_rank;

	sp_pifo_packet_scheduler #(
		.NUM_QUEUES (NUM_Q),
		.QUEUE_DEPTH(Q_DEPTH),
		.NUM_FLOWS  (N_FLOWS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.flow_id          (flow_id),
		.flow_weight      (flow_weight),
		.packet_handle    (packet_handle),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.queue_index      (queue_index),
		.packet_handle_out(packet_handle_out),
		.packet_rank      (packet_rank)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop: far beyond the slowest legal run, including the flow-memory
	// clearing pass that follows reset.
	initial begin
		#2_400_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Shadow scheduler state
	// ---------------------------------------------------------------------
	logic [31:0] bound_reg [NUM_Q];
	logic [31:0] round_now;
	logic [31:0] flow_finish [N_FLOWS];
	fifo_slot_t  fifo_q [NUM_Q][$];

	sched_result_t expected_results[$];
	int error_count = 0;
	int items_sent  = 0;
	bit no_idle     = 1'b0;
	int stall_left  = 0;

	// Advance the shadow scheduler by one accepted beat and return its result.
	function automatic sched_result_t predict_schedule(input sched_op_t op);
		sched_result_t res;
		logic [31:0]   rank;
		logic [31:0]   cost;
		logic [2:0]    target;
		bit            push_down;
		bit            found;
		fifo_slot_t    slot;

		res = '{ST_EMPTY, 3'd0, 16'd0, 32'd0};
		if (op.func == FUNC_ENQ) begin
			// start-time fair queueing: later of the current round and the flow's finish
			rank = ($signed(round_now) >= $signed(flow_finish[op.flow])) ?
				round_now : flow_finish[op.flow];
			target = 3'd0;
			push_down = 1'b1;
			// scan from the lowest priority upward for the first bound at or below rank
			for (int i = NUM_Q - 1; i >= 0; i--) begin
				if (push_down && $signed(rank) >= $signed(bound_reg[i])) begin
					target = i[2:0];
					push_down = 1'b0;
				end
			end
			if (fifo_q[target].size() >= Q_DEPTH) begin
				// full target: drop, leave every piece of state alone
				res = '{ST_DROP, target, op.handle, rank};
			end else begin
				slot = '{op.handle, rank};
				fifo_q[target] = {fifo_q[target], slot};
				if (push_down) begin
					cost = bound_reg[0] - rank;
					bound_reg[0] = rank;
					for (int q = 1; q < NUM_Q; q++)
						bound_reg[q] = bound_reg[q] - cost;
				end else begin
					bound_reg[target] = rank;
				end
				flow_finish[op.flow] = rank + {16'd0, op.weight};
				res = '{ST_ENQ, target, op.handle, rank};
			end
		end else begin
			found = 1'b0;
			// serve the highest-priority non-empty FIFO
			for (int q = 0; q < NUM_Q; q++) begin
				if (!found && fifo_q[q].size() != 0) begin
					slot = fifo_q[q].pop_front();
					round_now = slot.rank;
					res = '{ST_DEQ, q[2:0], slot.handle, slot.rank};
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Cycles to idle before the next beat; zero during no-idle stretches.
	function automatic int draw_idle();
		return no_idle ? 0 : int'($urandom_range(0, 4));
	endfunction

	// Random beat: most flows from a small hot set so finish rounds build up,
	// weights often at their extremes.
	function automatic sched_op_t random_op(input bit enq);
		sched_op_t op;

		op.func   = enq ? FUNC_ENQ : FUNC_DEQ;
		op.flow   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0:       op.weight = 16'h0000;
			1:       op.weight = 16'hFFFF;
			default: op.weight = 16'($urandom);
		endcase
		op.handle = 16'($urandom);
		return op;
	endfunction

	// Drive one beat, hold it until accepted, then log what it must produce.
	// Only one nonblocking write to in_valid lands in any time step.
	task automatic send_op(input sched_op_t op, input logic typed, input sched_result_t want);
		int            gap;
		sched_result_t res;

		gap = draw_idle();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func          <= op.func;
		flow_id       <= op.flow;
		flow_weight   <= op.weight;
		packet_handle <= op.handle;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		res = predict_schedule(op);
		expected_results = {expected_results, (typed ? want : res)};
		items_sent++;
	endtask

	// Drop valid and hold off until every outstanding result has drained.
	task automatic drain_pause();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result side: random stall per beat, compare against the oldest expectation
	// ---------------------------------------------------------------------
	task automatic check_result();
		sched_result_t want;

		if (expected_results.size() == 0) begin
			$error("unexpected result beat: status %0d queue %0d", status, queue_index);
			error_count++;
			return;
		end
		want = expected_results.pop_front();
		if (status !== want.st) begin
			$error("status: expected %0d, got %0d", want.st, status);
			error_count++;
		end
		if (queue_index !== want.qidx) begin
			$error("queue_index: expected %0d, got %0d", want.qidx, queue_index);
			error_count++;
		end
		if (packet_handle_out !== want.handle) begin
			$error("packet_handle_out: expected %0h, got %0h", want.handle, packet_handle_out);
			error_count++;
		end
		if (packet_rank !== want.rank) begin
			$error("packet_rank: expected %0d, got %0d", $signed(want.rank), packet_rank);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			check_result();
			stall_left = draw_idle();
			out_stall <= (stall_left != 0);
		end else if (out_stall) begin
			stall_left = stall_left - 1;
			out_stall <= (stall_left > 0);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	stim_row_t directed_rows [16];

	initial begin
		sched_op_t   op;
		int          kind;
		int          n;
		int          base;
		int          step;
		int          f;
		logic [31:0] lowest;

		// Directed table, walked from reset. Rows with a hand-written result trace
		// the obvious path: empty dequeue, extremes, push-up into queue 7 and 6.
		// Later rows fill queue 7 past its depth (drops), drain past empty, and
		// are left to the shadow scheduler.
		directed_rows = '{
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_EMPTY, 3'd0, 16'h0000, 32'd0}},
			'{'{FUNC_ENQ, 8'h00, 16'hFFFF, 16'hFFFF}, 8'd1, 1'b1,
				'{ST_ENQ, 3'd7, 16'hFFFF, 32'd0}},
			'{'{FUNC_ENQ, 8'hFF, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_ENQ, 3'd7, 16'h0000, 32'd0}},
			'{'{FUNC_ENQ, 8'h00, 16'h0010, 16'h1234}, 8'd1, 1'b1,
				'{ST_ENQ, 3'd7, 16'h1234, 32'd65535}},
			'{'{FUNC_DEQ, 8'hFF, 16'hFFFF, 16'hFFFF}, 8'd1, 1'b1,
				'{ST_DEQ, 3'd7, 16'hFFFF, 32'd0}},
			'{'{FUNC_ENQ, 8'h01, 16'h0005, 16'hA5A5}, 8'd1, 1'b1,
				'{ST_ENQ, 3'd6, 16'hA5A5, 32'd0}},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_DEQ, 3'd6, 16'hA5A5, 32'd0}},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_DEQ, 3'd7, 16'h0000, 32'd0}},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_DEQ, 3'd7, 16'h1234, 32'd65535}},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b1,
				'{ST_EMPTY, 3'd0, 16'h0000, 32'd0}},
			'{'{FUNC_ENQ, 8'h02, 16'h0001, 16'h5A5A}, 8'd1, 1'b1,
				'{ST_ENQ, 3'd7, 16'h5A5A, 32'd65535}},
			'{'{FUNC_ENQ, 8'h80, 16'h8000, 16'h8001}, 8'd1, 1'b0, UNTYPED},
			'{'{FUNC_ENQ, 8'hC8, 16'h0000, 16'h0F00}, 8'd66, 1'b0, UNTYPED},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd70, 1'b0, UNTYPED},
			'{'{FUNC_ENQ, 8'h00, 16'hFFFF, 16'h0000}, 8'd1, 1'b0, UNTYPED},
			'{'{FUNC_DEQ, 8'h00, 16'h0000, 16'h0000}, 8'd1, 1'b0, UNTYPED}
		};

		// shadow state after reset
		round_now = '0;
		for (int q = 0; q < NUM_Q; q++)
			bound_reg[q] = '0;
		for (int i = 0; i < N_FLOWS; i++)
			flow_finish[i] = '0;

		// drive every input known and hold reset, then release it
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = FUNC_ENQ;
		flow_id       = '0;
		flow_weight   = '0;
		packet_handle = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// the scheduler stalls through its flow-memory clear; send_op waits it out
		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				op = directed_rows[r].op;
				op.handle = op.handle + 16'(k);
				send_op(op, directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// Random phases until the item budget is spent. Each phase picks its own
		// idling mode so some stretches run back to back.
		drain_pause();
		while (items_sent < ITEM_BUDGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				drain_pause();
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				// mixed traffic, enqueue-heavy
				n = $urandom_range(10, 40);
				for (int k = 0; k < n; k++)
					send_op(random_op($urandom_range(0, 4) < 3), 1'b0, UNTYPED);
			end else if (kind < 6) begin
				// Ladder: seed eight flows with descending weights, send them again so
				// ranks fall queue by queue, then send the flow with the lowest finish
				// round to force a push-down.
				base = $urandom_range(0, N_FLOWS - 8);
				step = $urandom_range(1, 8191);
				for (int k = 0; k < 8; k++) begin
					op = random_op(1'b1);
					op.flow = 8'(base + k);
					op.weight = 16'((8 - k) * step);
					send_op(op, 1'b0, UNTYPED);
				end
				for (int k = 0; k < 8; k++) begin
					op = random_op(1'b1);
					op.flow = 8'(base + k);
					send_op(op, 1'b0, UNTYPED);
				end
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++) begin
					lowest = flow_finish[0];
					f = 0;
					for (int i = 1; i < N_FLOWS; i++) begin
						if ($signed(flow_finish[i]) < $signed(lowest)) begin
							lowest = flow_finish[i];
							f = i;
						end
					end
					op = random_op(1'b1);
					op.flow = 8'(f);
					send_op(op, 1'b0, UNTYPED);
				end
			end else if (kind < 8) begin
				// drain, often running past empty
				n = $urandom_range(5, 60);
				for (int k = 0; k < n; k++)
					send_op(random_op(1'b0), 1'b0, UNTYPED);
			end else begin
				// burst one flow at weight zero: same rank, same queue, possibly until it fills
				op = random_op(1'b1);
				op.weight = 16'h0000;
				n = $urandom_range(20, 70);
				for (int k = 0; k < n; k++) begin
					op.handle = 16'($urandom);
					send_op(op, 1'b0, UNTYPED);
				end
			end
		end

		// let the last results drain, then watch for anything stray
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
